FILE: rtl/tpb_pkg.sv
// Shared types and constants for the tangent-plane basis and scale core.
// Used by tpb_mac, tpb_dsu and the top level; depends on nothing.
package tpb_pkg;

  localparam int FRAC_BITS  = 30;
  localparam int INDEX_BITS = 21;
  localparam int ZONE_W     = 21;

  localparam int MA_W   = 34;
  localparam int MB_W   = 32;
  localparam int ACC_W  = MA_W + MB_W;
  localparam int ROOT_W = 32;
  localparam int RAD_W  = 2 * ROOT_W;

  // one multiply-accumulate request
  typedef struct packed {
    logic                   valid;
    logic                   clr;
    logic                   shift;
    logic                   sub;
    logic signed [MA_W-1:0] a;
    logic signed [MB_W-1:0] b;
  } mac_req_t;

  // divide / square root request
  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [RAD_W-1:0]  num;
    logic [ROOT_W-1:0] den;
  } dsu_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] result;
  } dsu_stat_t;

endpackage

FILE: rtl/tpb_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
// Optional floor shift by FRAC_BITS and subtract. Depends on tpb_pkg.
module tpb_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  tpb_pkg::mac_req_t                   req,
  output logic signed [tpb_pkg::ACC_W-1:0]    acc
);

  logic                              v1;
  logic                              clr1;
  logic                              shift1;
  logic                              sub1;
  logic signed [tpb_pkg::ACC_W-1:0]  prod;
  logic signed [tpb_pkg::ACC_W-1:0]  term;

  always_comb begin
    term = shift1 ? (prod >>> tpb_pkg::FRAC_BITS) : prod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1     <= req.valid;
      clr1   <= req.clr;
      shift1 <= req.shift;
      sub1   <= req.sub;
      prod   <= req.a * req.b;
      if (v1) begin
        acc <= (clr1 ? '0 : acc) + (sub1 ? -term : term);
      end
    end
  end

endmodule

FILE: rtl/tpb_dsu.sv
// Iterative divide / integer square root unit, one result bit per cycle.
// Divide saturates the quotient to all ones when it will not fit. Depends on tpb_pkg.
module tpb_dsu (
  input  logic                clk,
  input  logic                rst,
  input  tpb_pkg::dsu_req_t   req,
  output tpb_pkg::dsu_stat_t  stat
);

  localparam int RW    = tpb_pkg::ROOT_W;
  localparam int REM_W = RW + 3;
  localparam int CNT_W = $clog2(RW);

  logic              busy;
  logic              done;
  logic              is_sqrt;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  sub_op;
  logic [REM_W:0]    diff;
  logic [2*RW-1:0]   sh;
  logic [RW-1:0]     res;
  logic [RW-1:0]     den;
  logic              ge;

  always_comb begin
    rem_sh = is_sqrt ? {rem[REM_W-3:0], sh[2*RW-1 -: 2]} : {rem[REM_W-2:0], sh[2*RW-1]};
    sub_op = is_sqrt ? {1'b0, res, 2'b01} : {3'b000, den};
    diff   = {1'b0, rem_sh} - {1'b0, sub_op};
    ge     = ~diff[REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        is_sqrt <= req.is_sqrt;
        den     <= req.den;
        cnt     <= '0;
        res     <= '0;
        if (!req.is_sqrt && req.num[2*RW-1:RW] >= req.den) begin
          res  <= '1;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          busy <= 1'b1;
          rem  <= req.is_sqrt ? '0 : {3'b000, req.num[2*RW-1:RW]};
          sh   <= req.is_sqrt ? req.num : {req.num[RW-1:0], {RW{1'b0}}};
        end
      end else if (busy) begin
        rem <= ge ? diff[REM_W-1:0] : rem_sh;
        res <= {res[RW-2:0], ge};
        sh  <= is_sqrt ? (sh << 2) : (sh << 1);
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done   = done;
  assign stat.result = res;

endmodule

FILE: rtl/tangent_plane_basis_and_scale_core.sv
// Tangent-plane basis and position scale for one spherical triangle per word.
// Input channel: in_valid / in_stall with zone_index and three corner vectors
// (signed Q1.30). Output channel: out_valid / out_stall with the unit centroid,
// east and north axes, the running maximum scale and the degenerate flag.
// One word is worked at a time; in_stall is high from acceptance until the
// result is taken. A word makes up to 16 passes through the shared 32-step
// divide / square-root unit, one-bit normalize shifts for each unit vector,
// and sums of products on the shared multiply-accumulate unit. Corners whose
// radicand is not positive skip their square root and divides; a zero
// centroid or a centroid on the pole skips the east square root and divides.
// The result waits in the output registers while out_stall is high; no new
// word is taken until it leaves. Reset clears the sequencer and the running
// scale maximum to zero.
// Depends on tpb_pkg, tpb_mac and tpb_dsu.
module tangent_plane_basis_and_scale_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tpb_pkg::ZONE_W-1:0]         zone_index,
  input  logic signed [31:0]                 corner0_x,
  input  logic signed [31:0]                 corner0_y,
  input  logic signed [31:0]                 corner0_z,
  input  logic signed [31:0]                 corner1_x,
  input  logic signed [31:0]                 corner1_y,
  input  logic signed [31:0]                 corner1_z,
  input  logic signed [31:0]                 corner2_x,
  input  logic signed [31:0]                 corner2_y,
  input  logic signed [31:0]                 corner2_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tpb_pkg::ZONE_W-1:0]         zone_out,
  output logic signed [31:0]                 center_x,
  output logic signed [31:0]                 center_y,
  output logic signed [31:0]                 center_z,
  output logic signed [31:0]                 east_x,
  output logic signed [31:0]                 east_y,
  output logic signed [31:0]                 north_ax_x,
  output logic signed [31:0]                 north_ax_y,
  output logic signed [31:0]                 north_ax_z,
  output logic [31:0]                        scale_max,
  output logic                               degenerate
);

  typedef enum logic [2:0] {S_IDLE, S_NORM, S_MAC, S_SQRT, S_DIV, S_OUT} state_t;
  typedef enum logic [1:0] {M_CEN, M_EAST, M_COR} mode_t;
  typedef enum logic [2:0] {P_SQ, P_NV0, P_NV1, P_NV2, P_MU0, P_MU1, P_RAD} prog_t;

  localparam int FB    = tpb_pkg::FRAC_BITS;
  localparam int ACC_W = tpb_pkg::ACC_W;
  localparam logic [tpb_pkg::ZONE_W-1:0] ZONE_MASK =
    tpb_pkg::ZONE_W'((64'd1 << tpb_pkg::INDEX_BITS) - 64'd1);
  localparam logic signed [35:0]      MU_ONE  = 36'sd1 <<< FB;
  localparam logic signed [ACC_W-1:0] RAD_ONE = ACC_W'(1) <<< (2 * FB);
  localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO  = -ACC_W'(64'sd2147483648);

  function automatic logic [2:0] nops(input prog_t p);
    case (p)
      P_SQ:    nops = 3'd3;
      P_NV0:   nops = 3'd1;
      P_NV1:   nops = 3'd1;
      P_NV2:   nops = 3'd2;
      P_MU0:   nops = 3'd2;
      P_MU1:   nops = 3'd3;
      P_RAD:   nops = 3'd2;
      default: nops = 3'd1;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > SAT_HI) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < SAT_LO) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = 32'(v);
    end
  endfunction

  state_t                    state;
  mode_t                     mode;
  prog_t                     prog;
  logic [2:0]                step;
  logic [1:0]                k;
  logic                      issued;
  logic [tpb_pkg::ZONE_W-1:0] zone;
  logic signed [31:0]        cr [3][3];
  logic [33:0]               mag [3];
  logic                      vneg [3];
  logic signed [31:0]        c [3];
  logic signed [31:0]        e [2];
  logic signed [31:0]        nv [3];
  logic signed [35:0]        mu0;
  logic signed [35:0]        mu1;
  logic [63:0]               rad;
  logic [31:0]               root;
  logic [31:0]               smax;
  logic                      degen;

  logic signed [33:0]        sum [3];
  logic [1:0]                sidx;
  logic signed [32:0]        d_sel;
  logic signed [35:0]        mu_sel;
  logic signed [35:0]        amu_full;
  logic [FB-1:0]             amu;
  logic                      any_hi;
  logic                      any_mid;
  logic                      all_zero;
  logic                      mac_end;
  logic signed [35:0]        mu1_n;
  logic                      mu_ok;
  logic signed [ACC_W-1:0]   rad_d;
  logic signed [31:0]        q_s;
  logic [33:0]               ev_mag0;
  logic [33:0]               ev_mag1;
  logic signed [ACC_W-1:0]   acc;
  tpb_pkg::mac_req_t         mreq;
  tpb_pkg::dsu_req_t         dreq;
  tpb_pkg::dsu_stat_t        dstat;

  tpb_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .acc (acc)
  );

  tpb_dsu u_dsu (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .stat (dstat)
  );

  assign sum[0] = 34'(corner0_x) + 34'(corner1_x) + 34'(corner2_x);
  assign sum[1] = 34'(corner0_y) + 34'(corner1_y) + 34'(corner2_y);
  assign sum[2] = 34'(corner0_z) + 34'(corner1_z) + 34'(corner2_z);

  assign sidx     = step[1:0];
  assign d_sel    = 33'(cr[k][sidx]) - 33'(c[sidx]);
  assign mu_sel   = step[0] ? mu1 : mu0;
  assign amu_full = (mu_sel < 0) ? -mu_sel : mu_sel;
  assign amu      = amu_full[FB-1:0];
  assign mu1_n    = acc[35:0];
  assign rad_d    = RAD_ONE - acc;
  assign q_s      = vneg[sidx] ? -$signed(dstat.result) : $signed(dstat.result);
  assign ev_mag0  = (c[1] < 0) ? -34'(c[1]) : 34'(c[1]);
  assign ev_mag1  = (c[0] < 0) ? -34'(c[0]) : 34'(c[0]);
  assign mac_end  = (state == S_MAC) && (step == nops(prog) + 3'd1);
  assign mu_ok    = (mu0 > -MU_ONE) && (mu0 < MU_ONE) &&
                    (mu1_n > -MU_ONE) && (mu1_n < MU_ONE);

  // normalize window: largest magnitude in [2^30, 2^31)
  always_comb begin
    any_hi   = 1'b0;
    any_mid  = 1'b0;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any_hi   = any_hi | (|mag[i][33:31]);
      any_mid  = any_mid | (|mag[i][33:30]);
      all_zero = all_zero & (mag[i] == '0);
    end
  end

  always_comb begin
    mreq = '0;
    if (state == S_MAC && step < nops(prog)) begin
      mreq.valid = 1'b1;
      mreq.clr   = (step == 3'd0);
      case (prog)
        P_SQ: begin
          mreq.a = 34'(mag[sidx][30:0]);
          mreq.b = 32'(mag[sidx][30:0]);
        end
        P_NV0: begin
          mreq.shift = 1'b1;
          mreq.a     = -34'(c[2]);
          mreq.b     = e[1];
        end
        P_NV1: begin
          mreq.shift = 1'b1;
          mreq.a     = 34'(c[2]);
          mreq.b     = e[0];
        end
        P_NV2: begin
          mreq.shift = 1'b1;
          if (step == 3'd0) begin
            mreq.a = 34'(c[0]);
            mreq.b = e[1];
          end else begin
            mreq.a   = 34'(c[1]);
            mreq.b   = e[0];
            mreq.sub = 1'b1;
          end
        end
        P_MU0: begin
          mreq.shift = 1'b1;
          mreq.a     = 34'(d_sel);
          mreq.b     = e[sidx[0]];
        end
        P_MU1: begin
          mreq.shift = 1'b1;
          mreq.a     = 34'(d_sel);
          mreq.b     = nv[sidx];
        end
        P_RAD: begin
          mreq.a = 34'(mu_sel);
          mreq.b = 32'(mu_sel);
        end
        default: begin
          mreq.valid = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    dreq.start   = (state == S_SQRT || state == S_DIV) && !issued;
    dreq.is_sqrt = (state == S_SQRT);
    dreq.den     = root;
    if (state == S_SQRT) begin
      dreq.num = rad;
    end else if (mode == M_COR) begin
      dreq.num = 64'(amu) << FB;
    end else begin
      dreq.num = 64'(mag[sidx][30:0]) << FB;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      smax   <= '0;
      issued <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            zone     <= zone_index;
            cr[0][0] <= corner0_x;
            cr[0][1] <= corner0_y;
            cr[0][2] <= corner0_z;
            cr[1][0] <= corner1_x;
            cr[1][1] <= corner1_y;
            cr[1][2] <= corner1_z;
            cr[2][0] <= corner2_x;
            cr[2][1] <= corner2_y;
            cr[2][2] <= corner2_z;
            for (int i = 0; i < 3; i++) begin
              mag[i]  <= sum[i][33] ? 34'(-sum[i]) : 34'(sum[i]);
              vneg[i] <= sum[i][33];
            end
            mode  <= M_CEN;
            degen <= 1'b0;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (all_zero) begin
            if (mode == M_CEN) begin
              // zero centroid: east input is zero too
              c[0] <= '0;
              c[1] <= '0;
              c[2] <= '0;
              mode <= M_EAST;
            end else begin
              e[0]  <= '0;
              e[1]  <= '0;
              nv[0] <= '0;
              nv[1] <= '0;
              nv[2] <= '0;
              degen <= 1'b1;
              mode  <= M_COR;
              k     <= '0;
              prog  <= P_MU0;
              step  <= '0;
              state <= S_MAC;
            end
          end else if (any_hi) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (!any_mid) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            prog  <= P_SQ;
            step  <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          step <= step + 3'd1;
          if (mac_end) begin
            step <= '0;
            case (prog)
              P_SQ: begin
                rad    <= acc[63:0];
                issued <= 1'b0;
                state  <= S_SQRT;
              end
              P_NV0: begin
                nv[0] <= sat32(acc);
                prog  <= P_NV1;
              end
              P_NV1: begin
                nv[1] <= sat32(acc);
                prog  <= P_NV2;
              end
              P_NV2: begin
                nv[2] <= sat32(acc);
                mode  <= M_COR;
                k     <= '0;
                prog  <= P_MU0;
              end
              P_MU0: begin
                mu0  <= acc[35:0];
                prog <= P_MU1;
              end
              P_MU1: begin
                mu1 <= mu1_n;
                if (mu_ok) begin
                  prog <= P_RAD;
                end else begin
                  smax <= '1;
                  if (k == 2'd2) begin
                    state <= S_OUT;
                  end else begin
                    k    <= k + 2'd1;
                    prog <= P_MU0;
                  end
                end
              end
              P_RAD: begin
                if (rad_d > 0) begin
                  rad    <= rad_d[63:0];
                  issued <= 1'b0;
                  state  <= S_SQRT;
                end else begin
                  smax <= '1;
                  if (k == 2'd2) begin
                    state <= S_OUT;
                  end else begin
                    k    <= k + 2'd1;
                    prog <= P_MU0;
                  end
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SQRT: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (dstat.done) begin
            root   <= dstat.result;
            issued <= 1'b0;
            step   <= '0;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (dstat.done) begin
            issued <= 1'b0;
            step   <= step + 3'd1;
            case (mode)
              M_CEN: begin
                c[sidx] <= q_s;
                if (sidx == 2'd2) begin
                  // east input is (-cy, cx, 0)
                  mag[0]  <= ev_mag0;
                  mag[1]  <= ev_mag1;
                  mag[2]  <= '0;
                  vneg[0] <= (c[1] > 0);
                  vneg[1] <= c[0][31];
                  vneg[2] <= 1'b0;
                  mode    <= M_EAST;
                  state   <= S_NORM;
                end
              end
              M_EAST: begin
                e[sidx[0]] <= q_s;
                if (sidx == 2'd1) begin
                  prog  <= P_NV0;
                  step  <= '0;
                  state <= S_MAC;
                end
              end
              default: begin
                if (dstat.result > smax) begin
                  smax <= dstat.result;
                end
                if (sidx == 2'd1) begin
                  step <= '0;
                  if (k == 2'd2) begin
                    state <= S_OUT;
                  end else begin
                    k     <= k + 2'd1;
                    prog  <= P_MU0;
                    state <= S_MAC;
                  end
                end
              end
            endcase
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign zone_out   = zone & ZONE_MASK;
  assign center_x   = c[0];
  assign center_y   = c[1];
  assign center_z   = c[2];
  assign east_x     = e[0];
  assign east_y     = e[1];
  assign north_ax_x = nv[0];
  assign north_ax_y = nv[1];
  assign north_ax_z = nv[2];
  assign scale_max  = smax;
  assign degenerate = degen;

endmodule
